// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the background subtraction block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define GBS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// condition must never be true out of reset
`define GBS_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define GBS_ASSERT(lbl, clk, rst_n, prop)
`define GBS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== design/gbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbs_pkg
// Widths, constants, reciprocal table and pipeline word types.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int MAX_PIXELS  = 524288;
    localparam int PIXEL_BITS  = 8;
    localparam int ADDR_W      = $clog2(MAX_PIXELS);
    localparam int POS_W       = ADDR_W + 1;
    localparam int SUM_W       = 14;
    localparam int SQ_W        = 22;
    localparam int RAM_W       = SUM_W + SQ_W;
    localparam int FRAME_W     = 7;
    localparam int TRAIN_W     = 6;
    localparam int TMULT_W     = 4;
    localparam int N_W         = 6;
    localparam int MEAN_W      = 8;
    localparam int DEV_W       = 7;
    localparam int RECIP_W     = 31;
    localparam int RECIP_SHIFT = 30;
    localparam int PROD_W      = 54;
    localparam int DET_STAGES  = 17;

    localparam longint unsigned RECIP_ONE = 64'd1073741824;

    // ceil(2^30 / n), entry zero unused
    localparam logic [RECIP_W-1:0] RECIP_TABLE [64] = '{
        31'(RECIP_ONE),
        31'((RECIP_ONE + 0) / 1),   31'((RECIP_ONE + 1) / 2),   31'((RECIP_ONE + 2) / 3),
        31'((RECIP_ONE + 3) / 4),   31'((RECIP_ONE + 4) / 5),   31'((RECIP_ONE + 5) / 6),
        31'((RECIP_ONE + 6) / 7),   31'((RECIP_ONE + 7) / 8),   31'((RECIP_ONE + 8) / 9),
        31'((RECIP_ONE + 9) / 10),  31'((RECIP_ONE + 10) / 11), 31'((RECIP_ONE + 11) / 12),
        31'((RECIP_ONE + 12) / 13), 31'((RECIP_ONE + 13) / 14), 31'((RECIP_ONE + 14) / 15),
        31'((RECIP_ONE + 15) / 16), 31'((RECIP_ONE + 16) / 17), 31'((RECIP_ONE + 17) / 18),
        31'((RECIP_ONE + 18) / 19), 31'((RECIP_ONE + 19) / 20), 31'((RECIP_ONE + 20) / 21),
        31'((RECIP_ONE + 21) / 22), 31'((RECIP_ONE + 22) / 23), 31'((RECIP_ONE + 23) / 24),
        31'((RECIP_ONE + 24) / 25), 31'((RECIP_ONE + 25) / 26), 31'((RECIP_ONE + 26) / 27),
        31'((RECIP_ONE + 27) / 28), 31'((RECIP_ONE + 28) / 29), 31'((RECIP_ONE + 29) / 30),
        31'((RECIP_ONE + 30) / 31), 31'((RECIP_ONE + 31) / 32), 31'((RECIP_ONE + 32) / 33),
        31'((RECIP_ONE + 33) / 34), 31'((RECIP_ONE + 34) / 35), 31'((RECIP_ONE + 35) / 36),
        31'((RECIP_ONE + 36) / 37), 31'((RECIP_ONE + 37) / 38), 31'((RECIP_ONE + 38) / 39),
        31'((RECIP_ONE + 39) / 40), 31'((RECIP_ONE + 40) / 41), 31'((RECIP_ONE + 41) / 42),
        31'((RECIP_ONE + 42) / 43), 31'((RECIP_ONE + 43) / 44), 31'((RECIP_ONE + 44) / 45),
        31'((RECIP_ONE + 45) / 46), 31'((RECIP_ONE + 46) / 47), 31'((RECIP_ONE + 47) / 48),
        31'((RECIP_ONE + 48) / 49), 31'((RECIP_ONE + 49) / 50), 31'((RECIP_ONE + 50) / 51),
        31'((RECIP_ONE + 51) / 52), 31'((RECIP_ONE + 52) / 53), 31'((RECIP_ONE + 53) / 54),
        31'((RECIP_ONE + 54) / 55), 31'((RECIP_ONE + 55) / 56), 31'((RECIP_ONE + 56) / 57),
        31'((RECIP_ONE + 57) / 58), 31'((RECIP_ONE + 58) / 59), 31'((RECIP_ONE + 59) / 60),
        31'((RECIP_ONE + 60) / 61), 31'((RECIP_ONE + 61) / 62), 31'((RECIP_ONE + 62) / 63)
    };

    // pixel handed from the model store to the detection pipeline
    typedef struct packed {
        logic [PIXEL_BITS-1:0] x;
        logic [N_W-1:0]        n;
        logic [SUM_W-1:0]      sum;
        logic [SQ_W-1:0]       sq;
    } det_in_t;

    // word carried through the detection pipeline
    typedef struct packed {
        logic [PIXEL_BITS-1:0] x;
        logic [N_W-1:0]        n;
        logic [SUM_W-1:0]      sum;
        logic [SQ_W-1:0]       sq;
        logic [RECIP_W-1:0]    recip;
        logic [PROD_W-1:0]     prod;
        logic [MEAN_W-1:0]     mean;
        logic [21:0]           ms;
        logic [15:0]           mm;
        logic [21:0]           nmm;
        logic signed [24:0]    t;
        logic [22:0]           num;
        logic [13:0]           var_c;
        logic [DEV_W-1:0]      root;
        logic [10:0]           thr;
        logic [PIXEL_BITS-1:0] diff;
        logic                  fg;
    } det_t;

endpackage

// ===== design/gbs_ram.sv =====
// ----------------------------------------------------------------------------
// gbs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/gbs_detect.sv =====
// ----------------------------------------------------------------------------
// gbs_detect
// Pipelined mean, deviation and threshold decision for detection pixels.
// ----------------------------------------------------------------------------
module gbs_detect (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  gbs_pkg::det_in_t                  in_word,
    input  logic [gbs_pkg::TMULT_W-1:0]       threshold_mult,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              out_fg,
    output logic [gbs_pkg::MEAN_W-1:0]        out_mean,
    output logic [gbs_pkg::DEV_W-1:0]         out_dev
);

    localparam int D = gbs_pkg::DET_STAGES;

    gbs_pkg::det_t det_reg  [D];
    gbs_pkg::det_t det_next [D];
    logic          valid_reg [D];
    logic          stage_ready [D+1];

    // one step of the datapath for stage k
    function automatic gbs_pkg::det_t det_stage(input int unsigned k,
                                                input gbs_pkg::det_t d,
                                                input logic [gbs_pkg::TMULT_W-1:0] tm);
        gbs_pkg::det_t       r;
        logic [14:0]         q;
        logic [23:0]         vq;
        logic signed [24:0]  acc;
        logic [6:0]          trial;
        logic [13:0]         sq_trial;
        int unsigned         bitpos;
        r        = d;
        q        = '0;
        vq       = '0;
        acc      = '0;
        trial    = '0;
        sq_trial = '0;
        bitpos   = 0;
        case (k)
            1: r.prod = gbs_pkg::PROD_W'(45'(d.sum) * 45'(d.recip));
            2:
            begin
                q      = d.prod[gbs_pkg::RECIP_SHIFT +: 15];
                r.mean = (q > 15'd255) ? 8'd255 : q[7:0];
            end
            3:
            begin
                r.ms = 22'(d.mean) * 22'(d.sum);
                r.mm = 16'(d.mean) * 16'(d.mean);
            end
            4:
            begin
                r.nmm = 22'(d.n) * 22'(d.mm);
                r.t   = $signed({3'b000, d.sq}) - $signed({2'b00, d.ms, 1'b0});
            end
            5:
            begin
                acc   = d.t + $signed({3'b000, d.nmm});
                r.num = acc[24] ? 23'd0 : acc[22:0];
            end
            6: r.prod = gbs_pkg::PROD_W'(d.num) * gbs_pkg::PROD_W'(d.recip);
            7:
            begin
                vq      = d.prod[gbs_pkg::RECIP_SHIFT +: 24];
                r.var_c = (|vq[23:14]) ? 14'h3FFF : vq[13:0];
            end
            8, 9, 10, 11, 12, 13, 14:
            begin
                // one root bit a stage, most significant first
                bitpos   = 14 - k;
                trial    = d.root | (7'd1 << bitpos);
                sq_trial = 14'(trial) * 14'(trial);
                if (sq_trial <= d.var_c)
                begin
                    r.root = trial;
                end
            end
            15:
            begin
                r.thr  = 11'(tm) * 11'(d.root);
                r.diff = (d.x > d.mean) ? (d.x - d.mean) : (d.mean - d.x);
            end
            16: r.fg = ({3'b000, d.diff} > d.thr);
            default: r = d;
        endcase
        return r;
    endfunction

    // ready runs back from the output
    assign stage_ready[D] = out_ready;
    for (genvar g = 0; g < D; g++)
    begin : g_ready
        assign stage_ready[g] = !valid_reg[g] || stage_ready[g+1];
    end

    // load the entry stage and compute each later stage
    always_comb
    begin
        det_next[0]       = '0;
        det_next[0].x     = in_word.x;
        det_next[0].n     = in_word.n;
        det_next[0].sum   = in_word.sum;
        det_next[0].sq    = in_word.sq;
        det_next[0].recip = gbs_pkg::RECIP_TABLE[in_word.n];
        for (int k = 1; k < D; k++)
        begin
            det_next[k] = det_stage(k, det_reg[k-1], threshold_mult);
        end
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < D; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < D; k++)
            begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (stage_ready[0] && in_valid)
        begin
            det_reg[0] <= det_next[0];
        end
        for (int k = 1; k < D; k++)
        begin
            if (stage_ready[k] && valid_reg[k-1])
            begin
                det_reg[k] <= det_next[k];
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[D-1];
    assign out_fg    = det_reg[D-1].fg;
    assign out_mean  = det_reg[D-1].mean;
    assign out_dev   = det_reg[D-1].root;

endmodule

// ===== design/gaussian_background_subtract_unit.sv =====
// ----------------------------------------------------------------------------
// gaussian_background_subtract_unit
// Per-pixel single Gaussian background model with foreground detection.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on s_tvalid/s_tready in raster order, s_tuser[0] marking the
//   first pixel of a frame. The first frame after reset is dropped, the next
//   train_frames frames (zero taken as one) fill the per-pixel sum and sum of squares, and every
//   later frame is classified. One result word per detection pixel leaves on
//   m_tvalid/m_tready; training and dropped pixels give no word.
//   Throughput is one pixel per cycle while m_tready does not stall the
//   pipeline: the model store is one 36-bit RAM read at accept and written in
//   the next cycle, with a bypass for back to back hits on one entry. On the
//   way to m_tvalid the store stage register loads at accept, then a 17-stage
//   detection pipeline follows (reciprocal multiplies, a seven-stage root,
//   threshold compare).
//   Reset clears the frame counters and the pipeline valid bits; the model
//   store is not cleared and needs no clearing pass. A stall on m_tready
//   backs up through the pipeline stage by stage and lowers s_tready only
//   once the pipeline is full. Write cfg_* only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gaussian_background_subtract_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic [0:0]  s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] mean_level, [14:8] deviation, [15] zero
    output logic [0:0]  m_tuser,   // [0] foreground
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam logic [1:0] CFG_TRAIN_FRAMES   = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD_MULT = 2'd1;

    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_DETECT = 2'd2
    } mode_t;

    // configuration
    logic [gbs_pkg::TRAIN_W-1:0] train_frames_reg;
    logic [gbs_pkg::TMULT_W-1:0] threshold_mult_reg;

    // frame tracking
    logic [gbs_pkg::POS_W-1:0]   position_reg, position_next;
    logic [gbs_pkg::FRAME_W-1:0] frame_number_reg, frame_number_next;
    logic                        model_ready_reg, model_ready_next;

    // store stage
    logic                           v0_reg, v0_next;
    mode_t                          mode_reg, mode_next;
    logic [gbs_pkg::ADDR_W-1:0]     idx_reg;
    logic [gbs_pkg::PIXEL_BITS-1:0] x_reg;
    logic [gbs_pkg::N_W-1:0]        n_reg, n_next;
    logic                           ignore_now;
    logic [gbs_pkg::POS_W-1:0]      idx_now;

    // bypass of the last store write
    logic                        fwd_valid_reg;
    logic [gbs_pkg::ADDR_W-1:0]  fwd_addr_reg;
    logic [gbs_pkg::RAM_W-1:0]   fwd_data_reg;

    logic                        accept, leave0, ram_we;
    logic [gbs_pkg::RAM_W-1:0]   ram_q, cur_word, new_word;
    logic [15:0]                 x_sq;
    logic [gbs_pkg::FRAME_W-1:0] tf_eff;

    logic                        det_valid, det_ready;
    gbs_pkg::det_in_t            det_word;
    logic                        out_fg;
    logic [gbs_pkg::MEAN_W-1:0]  out_mean;
    logic [gbs_pkg::DEV_W-1:0]   out_dev;

    // configuration writes
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            train_frames_reg   <= 6'd19;
            threshold_mult_reg <= 4'd3;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TRAIN_FRAMES:   train_frames_reg   <= cfg_data[gbs_pkg::TRAIN_W-1:0];
                CFG_THRESHOLD_MULT: threshold_mult_reg <= cfg_data[gbs_pkg::TMULT_W-1:0];
                default:            ;
            endcase
        end
    end

    // handshake of the store stage
    assign leave0   = v0_reg && ((mode_reg != MODE_DETECT) || det_ready);
    assign s_tready = !v0_reg || leave0;
    assign accept   = s_tvalid && s_tready;

    // frame phase and position for the arriving pixel
    always_comb
    begin
        tf_eff            = (train_frames_reg == '0) ? 7'd1 : {1'b0, train_frames_reg};
        frame_number_next = frame_number_reg;
        model_ready_next  = model_ready_reg;
        idx_now           = position_reg;
        if (s_tuser[0])
        begin
            idx_now = '0;
            if (!model_ready_reg)
            begin
                if ((frame_number_reg >= 7'd1) && (frame_number_reg >= tf_eff + 7'd1))
                begin
                    model_ready_next = 1'b1;
                end
                else
                begin
                    frame_number_next = frame_number_reg + 7'd1;
                end
            end
        end
        position_next = (idx_now < gbs_pkg::POS_W'(gbs_pkg::MAX_PIXELS)) ?
                        idx_now + 1'b1 : idx_now;
        ignore_now = (frame_number_next == '0) ||
                     (idx_now >= gbs_pkg::POS_W'(gbs_pkg::MAX_PIXELS)) ||
                     (!model_ready_next && (frame_number_next == 7'd1));
        if (model_ready_next)
        begin
            mode_next = MODE_DETECT;
        end
        else if (frame_number_next == 7'd2)
        begin
            mode_next = MODE_WRITE;
        end
        else
        begin
            mode_next = MODE_ADD;
        end
        n_next = (frame_number_next < 7'd3) ? 6'd1 : 6'(frame_number_next - 7'd2);
        v0_next = accept ? !ignore_now : (leave0 ? 1'b0 : v0_reg);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg     <= '0;
            frame_number_reg <= '0;
            model_ready_reg  <= 1'b0;
            v0_reg           <= 1'b0;
            fwd_valid_reg    <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            if (accept)
            begin
                position_reg     <= position_next;
                frame_number_reg <= frame_number_next;
                model_ready_reg  <= model_ready_next;
            end
            if (ram_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // payload of the store stage and of the bypass
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode_next;
            idx_reg  <= idx_now[gbs_pkg::ADDR_W-1:0];
            x_reg    <= s_tdata;
            n_reg    <= n_next;
        end
        if (ram_we)
        begin
            fwd_addr_reg <= idx_reg;
            fwd_data_reg <= new_word;
        end
    end

    // model store, read at accept
    gbs_ram #(
        .WIDTH (gbs_pkg::RAM_W),
        .DEPTH (gbs_pkg::MAX_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (new_word),
        .re    (accept),
        .raddr (idx_now[gbs_pkg::ADDR_W-1:0]),
        .rdata (ram_q)
    );

    // take the newest value of the entry and update it for training
    always_comb
    begin
        cur_word = (fwd_valid_reg && (fwd_addr_reg == idx_reg)) ? fwd_data_reg : ram_q;
        x_sq     = 16'(x_reg) * 16'(x_reg);
        if (mode_reg == MODE_WRITE)
        begin
            new_word = {gbs_pkg::SUM_W'(x_reg), gbs_pkg::SQ_W'(x_sq)};
        end
        else
        begin
            new_word = {cur_word[gbs_pkg::RAM_W-1:gbs_pkg::SQ_W] + gbs_pkg::SUM_W'(x_reg),
                        cur_word[gbs_pkg::SQ_W-1:0] + gbs_pkg::SQ_W'(x_sq)};
        end
    end

    assign ram_we = v0_reg && (mode_reg != MODE_DETECT);

    // hand detection pixels on: pixel, sample count, then sum and square sum
    assign det_valid = v0_reg && (mode_reg == MODE_DETECT);
    assign det_word  = {x_reg, n_reg, cur_word};

    gbs_detect u_detect (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (det_valid),
        .in_ready       (det_ready),
        .in_word        (det_word),
        .threshold_mult (threshold_mult_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_fg         (out_fg),
        .out_mean       (out_mean),
        .out_dev        (out_dev)
    );

    assign m_tdata = {1'b0, out_dev, out_mean};
    assign m_tuser = out_fg;

    `GBS_ASSERT(a_model_ready_sticky, clk, rst_n, model_ready_reg |=> model_ready_reg)
    `GBS_NEVER(a_position_range, clk, rst_n, position_reg > gbs_pkg::POS_W'(gbs_pkg::MAX_PIXELS))
    `GBS_NEVER(a_detect_before_model, clk, rst_n, v0_reg && (mode_reg == MODE_DETECT) && !model_ready_reg)

endmodule

// ===== tb/gbs_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gbs_tb_pkg
// Register indexes of the configuration channel, shared by stimulus and checker.
// ----------------------------------------------------------------------------
package gbs_tb_pkg;

    localparam logic [1:0] REG_TRAIN_FRAMES   = 2'd0;
    localparam logic [1:0] REG_THRESHOLD_MULT = 2'd1;

endpackage

// ===== tb/gbs_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gbs_checker
// Watches the pixel, result and configuration channels, keeps its own copy of
// the per-pixel background model and compares every result word in order.
// ----------------------------------------------------------------------------
module gbs_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);

    typedef struct {
        bit                          fg;
        bit [gbs_pkg::MEAN_W-1:0]    mean;
        bit [gbs_pkg::DEV_W-1:0]     dev;
    } verdict_t;

    verdict_t                      verdict_q[$];
    bit [gbs_pkg::SUM_W-1:0]       bg_sum[int];
    bit [gbs_pkg::SQ_W-1:0]        bg_sq[int];
    int                            pix_pos;
    int                            frame_cnt;
    bit                            model_done;
    bit [gbs_pkg::TRAIN_W-1:0]     train_len;
    bit [gbs_pkg::TMULT_W-1:0]     thr_mult;

    function automatic int isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 15; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return int'(r);
    endfunction

    // advance the background model by one pixel; queue a verdict on detection
    function automatic void model_pixel(bit [7:0] x, bit start);
        int      tf;
        int      idx;
        int      n;
        int      s;
        int      m;
        int      dev;
        int      diff;
        longint  num;
        bit [gbs_pkg::SUM_W-1:0] s_old;
        bit [gbs_pkg::SQ_W-1:0]  q_old;
        verdict_t v;
        tf = (train_len == 0) ? 1 : int'(train_len);
        if (start)
        begin
            pix_pos = 0;
            if (!model_done)
            begin
                if (frame_cnt >= 1 && frame_cnt >= tf + 1)
                    model_done = 1;
                else
                    frame_cnt++;
            end
        end
        idx = pix_pos;
        if (pix_pos < gbs_pkg::MAX_PIXELS)
            pix_pos++;
        if (frame_cnt == 0 || idx >= gbs_pkg::MAX_PIXELS)
            return;
        if (!model_done)
        begin
            if (frame_cnt == 1)
                return;
            if (frame_cnt == 2)
            begin
                bg_sum[idx] = gbs_pkg::SUM_W'(x);
                bg_sq[idx]  = gbs_pkg::SQ_W'(int'(x) * int'(x));
            end
            else
            begin
                s_old = bg_sum.exists(idx) ? bg_sum[idx] : '0;
                q_old = bg_sq.exists(idx) ? bg_sq[idx] : '0;
                bg_sum[idx] = s_old + gbs_pkg::SUM_W'(x);
                bg_sq[idx]  = q_old + gbs_pkg::SQ_W'(int'(x) * int'(x));
            end
            return;
        end
        n = frame_cnt - 2;
        if (n < 1)
            n = 1;
        s = bg_sum.exists(idx) ? int'(bg_sum[idx]) : 0;
        m = s / n;
        if (m > 255)
            m = 255;
        num = longint'(bg_sq.exists(idx) ? bg_sq[idx] : 0) - 2 * longint'(m) * s
            + longint'(n) * m * m;
        if (num < 0)
            num = 0;
        dev = isqrt(longint'(num / n));
        if (dev > 127)
            dev = 127;
        diff = (int'(x) > m) ? int'(x) - m : m - int'(x);
        v.fg   = diff > int'(thr_mult) * dev;
        v.mean = gbs_pkg::MEAN_W'(m);
        v.dev  = gbs_pkg::DEV_W'(dev);
        verdict_q = {verdict_q, v};
    endfunction

    function automatic void flag_mismatch(string what, int want, int got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
                     $realtime, what, results_seen, want, got);
    endfunction

    // track configuration, pixels and results
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t v;
        if (!rst_n)
        begin
            verdict_q.delete();
            pix_pos    = 0;
            frame_cnt  = 0;
            model_done = 0;
            train_len  = 6'd19;
            thr_mult   = 4'd3;
            pending    = 0;
            fail_count = 0;
            results_seen <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == gbs_tb_pkg::REG_TRAIN_FRAMES)
                    train_len = cfg_data[gbs_pkg::TRAIN_W-1:0];
                else if (cfg_index == gbs_tb_pkg::REG_THRESHOLD_MULT)
                    thr_mult = cfg_data[gbs_pkg::TMULT_W-1:0];
            end
            if (s_tvalid && s_tready)
                model_pixel(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result word with none expected", $realtime);
                end
                else
                begin
                    v = verdict_q.pop_front();
                    if (m_tuser[0] != v.fg)
                        flag_mismatch("foreground", v.fg, m_tuser[0]);
                    if (m_tdata[7:0] != v.mean)
                        flag_mismatch("mean_level", v.mean, m_tdata[7:0]);
                    if (m_tdata[14:8] != v.dev)
                        flag_mismatch("deviation", v.dev, m_tdata[14:8]);
                end
                results_seen <= results_seen + 1;
            end
            pending = verdict_q.size();
        end
    end

    // report verdicts never matched
    task automatic report_leftover();
        if (verdict_q.size() != 0)
        begin
            fail_count += verdict_q.size();
            $display("%0d expected results never arrived", verdict_q.size());
        end
    endtask

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Trains the background model on noisy frames around per-pixel base levels,
// then streams detection frames under several threshold settings with random
// gaps on both sides; the checker scores every result word.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int FRAME_LEN     = 12;
    localparam int SETTLE_CYCLES = 30;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_PIXELS = 1600;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    int fail_count;
    int pending;
    int results_seen;
    int pixels_sent;
    int quiet_cycles;
    int sink_hold;
    bit no_gaps;
    int base_level[FRAME_LEN];
    int noise_amp[FRAME_LEN];

    gaussian_background_subtract_unit DUT (.*);

    gbs_checker u_checker (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result sink with random stalls
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            m_tready <= 1'b0;
            sink_hold--;
        end
        else
        begin
            sink_hold = pick_gap();
            m_tready <= (sink_hold == 0);
            if (sink_hold > 0)
                sink_hold--;
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("gaussian_background_subtract_unit test failed");
            $finish;
        end
    end

    task automatic send_pixel(bit [7:0] pix, bit start);
        int g;
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pixels_sent++;
        g = pick_gap();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // hold the sender until every result is back and the pipe has drained
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sample near the pixel's base level, or an outlier
    function automatic bit [7:0] scene_pixel(int i, bit outlier);
        int v;
        if (outlier)
            return 8'($urandom_range(0, 255));
        v = base_level[i] + $urandom_range(0, 2 * noise_amp[i]) - noise_amp[i];
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    task automatic send_frame(int len, int outlier_pct);
        for (int i = 0; i < len; i++)
            send_pixel(scene_pixel(i, $urandom_range(0, 99) < outlier_pct), i == 0);
    endtask

    task automatic detect_phase(int pixel_budget);
        int sent;
        int len;
        sent = 0;
        while (sent < pixel_budget)
        begin
            len = $urandom_range(1, FRAME_LEN);
            no_gaps = ($urandom_range(0, 5) == 0);
            send_frame(len, 30);
            sent += len;
        end
        no_gaps = 0;
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        sink_hold = 0;
        no_gaps   = 0;
        pixels_sent  = 0;
        quiet_cycles = 0;
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            base_level[i] = $urandom_range(0, 255);
            noise_amp[i]  = $urandom_range(0, 20);
        end
        // flat pixels with no noise and pixels pinned at the rails
        base_level[0] = 0;   noise_amp[0] = 0;
        base_level[1] = 255; noise_amp[1] = 0;
        base_level[2] = 128; noise_amp[2] = 0;
        base_level[3] = 0;
        base_level[4] = 255;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(gbs_tb_pkg::REG_TRAIN_FRAMES, 8'd63);
        write_reg(gbs_tb_pkg::REG_THRESHOLD_MULT, 8'd15);

        // pixels before any frame start, then the dropped frame
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hA5, 1'b0);
        for (int i = 0; i < FRAME_LEN + 4; i++)
            send_pixel(8'($urandom_range(0, 255)), i == 0);

        // training: the first frame sets the full frame length
        for (int f = 0; f < 7; f++)
            send_frame(FRAME_LEN, 0);
        drain();

        // cut training short below the frames already trained
        write_reg(gbs_tb_pkg::REG_TRAIN_FRAMES, 8'd4);
        send_frame(FRAME_LEN, 0);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd129, 1'b0);
        drain();

        // threshold at zero: any difference from the mean is foreground
        write_reg(gbs_tb_pkg::REG_THRESHOLD_MULT, 8'd0);
        write_reg(gbs_tb_pkg::REG_TRAIN_FRAMES, 8'd0);
        detect_phase(RANDOM_PIXELS / 4);
        drain();

        write_reg(gbs_tb_pkg::REG_THRESHOLD_MULT, 8'd15);
        write_reg(gbs_tb_pkg::REG_TRAIN_FRAMES, 8'd63);
        detect_phase(RANDOM_PIXELS / 4);
        drain();

        write_reg(gbs_tb_pkg::REG_THRESHOLD_MULT, 8'($urandom_range(1, 14)));
        detect_phase(RANDOM_PIXELS / 4);
        drain();

        write_reg(gbs_tb_pkg::REG_THRESHOLD_MULT, 8'd3);
        detect_phase(RANDOM_PIXELS / 4);
        drain();

        u_checker.report_leftover();
        $display("run covered %0d pixels: dropped frame, 7 training frames, cut-short training,",
                 pixels_sent);
        $display("and %0d detection results across thresholds 0, 15, random and 3",
                 results_seen);
        if (fail_count == 0)
            $display("gaussian_background_subtract_unit test passed");
        else
            $display("gaussian_background_subtract_unit test failed");
        $finish;
    end

endmodule
